// ===== rtl/gsci_pkg.sv =====
// ----------------------------------------------------------------------------
// gsci_pkg
// shared types and constants of the gpio/spi command interpreter
// ----------------------------------------------------------------------------
package gsci_pkg;

  // opcode field, top three bits of a command byte
  typedef enum logic [2:0] {
    OP_RD_PORT = 3'd0,
    OP_WR_PORT = 3'd1,
    OP_RD_PIN  = 3'd2,
    OP_WR_PIN  = 3'd3,
    OP_SPI     = 3'd4
  } op_e;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOAD,
    BK_OUT
  } bk_state_e;

  localparam int unsigned NUM_PINS      = 7;
  localparam int unsigned CMD_Q_DEPTH   = 2;
  localparam logic [4:0]  PORT_ONE      = 5'd1;
  localparam logic [4:0]  PORT_THREE    = 5'd3;
  localparam logic [4:0]  LAST_PIN      = 5'd6;
  localparam int unsigned PIN_MOSI      = 4;
  localparam int unsigned PIN_SCK       = 6;
  localparam logic [7:0]  UNKNOWN_PORT  = 8'hFF;
  localparam logic [6:0]  PIN_RESET     = 7'h7F;
  localparam logic [7:0]  PORT_RESET    = 8'hFF;

  typedef struct packed {
    logic       mode;
    logic [7:0] code;
    logic [7:0] port1_levels;
    logic [7:0] port3_levels;
    logic [6:0] pin_levels;
    logic [7:0] miso_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       last;
    logic [5:0] length;
    logic [7:0] port1_drive;
    logic [7:0] port3_drive;
    logic [6:0] pin_drive;
    logic       overflow;
  } out_t;

  // decoded command passed from front to back
  typedef struct packed {
    logic       poll;
    logic       push_en;
    logic [7:0] push_data;
    logic       port1_we;
    logic       port3_we;
    logic [7:0] port_data;
    logic [6:0] pin_mask;
    logic [6:0] pin_val;
  } cmd_t;

endpackage

// ===== rtl/gsci_front.sv =====
// ----------------------------------------------------------------------------
// gsci_front
// accepts items, tracks opcode/operand phase and decodes commands
// ----------------------------------------------------------------------------
module gsci_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gsci_pkg::in_t in_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output gsci_pkg::cmd_t cmd_o
);

  logic       phase_q, phase_d;
  logic [2:0] pend_q, pend_d;
  logic [4:0] target_q, target_d;
  logic       accept;
  logic       effect;
  logic [2:0] op;

  assign in_ready_o  = cmd_ready_i;
  assign accept      = in_valid_i & in_ready_o;
  assign cmd_valid_o = in_valid_i & effect;
  assign op          = in_i.code[7:5];

  always_comb begin
    phase_d  = phase_q;
    pend_d   = pend_q;
    target_d = target_q;
    effect   = 1'b0;
    cmd_o    = '0;
    if (in_i.mode) begin
      cmd_o.poll = 1'b1;
      effect     = 1'b1;
    end else if (!phase_q) begin
      pend_d = op;
      case (op)
        gsci_pkg::OP_RD_PORT: begin
          target_d        = in_i.code[4:0];
          cmd_o.push_en   = 1'b1;
          cmd_o.push_data = (target_d == gsci_pkg::PORT_ONE)   ? in_i.port1_levels :
                            (target_d == gsci_pkg::PORT_THREE) ? in_i.port3_levels :
                            gsci_pkg::UNKNOWN_PORT;
          effect          = 1'b1;
        end
        gsci_pkg::OP_WR_PORT: begin
          target_d = in_i.code[4:0];
          phase_d  = 1'b1;
        end
        gsci_pkg::OP_RD_PIN: begin
          target_d        = in_i.code[4:0];
          cmd_o.push_en   = 1'b1;
          cmd_o.push_data = (target_d <= gsci_pkg::LAST_PIN) ?
                            {7'd0, in_i.pin_levels[target_d[2:0]]} : 8'd1;
          effect          = 1'b1;
        end
        gsci_pkg::OP_WR_PIN: begin
          target_d = {1'b0, in_i.code[3:0]};
          if (target_d <= gsci_pkg::LAST_PIN) begin
            cmd_o.pin_mask[target_d[2:0]] = 1'b1;
            cmd_o.pin_val[target_d[2:0]]  = in_i.code[4];
            effect                        = 1'b1;
          end
        end
        gsci_pkg::OP_SPI: begin
          phase_d = 1'b1;
        end
        default: begin
        end
      endcase
    end else begin
      phase_d = 1'b0;
      case (pend_q)
        gsci_pkg::OP_WR_PORT: begin
          cmd_o.port_data = in_i.code;
          cmd_o.port1_we  = (target_q == gsci_pkg::PORT_ONE);
          cmd_o.port3_we  = (target_q == gsci_pkg::PORT_THREE);
          effect          = cmd_o.port1_we | cmd_o.port3_we;
        end
        gsci_pkg::OP_SPI: begin
          cmd_o.push_en                      = 1'b1;
          cmd_o.push_data                    = in_i.miso_byte;
          cmd_o.pin_mask[gsci_pkg::PIN_MOSI] = 1'b1;
          cmd_o.pin_val[gsci_pkg::PIN_MOSI]  = in_i.code[0];
          cmd_o.pin_mask[gsci_pkg::PIN_SCK]  = 1'b1;
          cmd_o.pin_val[gsci_pkg::PIN_SCK]   = 1'b0;
          effect                             = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= 1'b0;
      pend_q   <= 3'd0;
      target_q <= 5'd0;
    end else if (accept) begin
      phase_q  <= phase_d;
      pend_q   <= pend_d;
      target_q <= target_d;
    end
  end

endmodule

// ===== rtl/gsci_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// gsci_cmd_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module gsci_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  gsci_pkg::cmd_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output gsci_pkg::cmd_t rd_data_o
);

  localparam int unsigned Depth = gsci_pkg::CMD_Q_DEPTH;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(Depth + 1);

  gsci_pkg::cmd_t   mem_q [Depth];
  logic [AW-1:0]    wr_idx_q, rd_idx_q;
  logic [CW-1:0]    cnt_q;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != CW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_idx_q];
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_valid_o & rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_idx_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_idx_q <= (wr_idx_q == AW'(Depth - 1)) ? '0 : wr_idx_q + AW'(1);
      end
      if (pop) begin
        rd_idx_q <= (rd_idx_q == AW'(Depth - 1)) ? '0 : rd_idx_q + AW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/gsci_back.sv =====
// ----------------------------------------------------------------------------
// gsci_back
// executes commands: latches, result ring and poll drain
// ----------------------------------------------------------------------------
module gsci_back #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  gsci_pkg::cmd_t cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output gsci_pkg::out_t out_o
);

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned FW = $clog2(RING_DEPTH + 1);

  gsci_pkg::bk_state_e state_q, state_d;
  logic [7:0]    ring [RING_DEPTH];
  logic [7:0]    rdata_q;
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FW-1:0] fill_q, fill_d, cnt_q, cnt_d, len_q, len_d;
  logic          ovf_q, ovf_d;
  logic [7:0]    p1_q, p1_d, p3_q, p3_d;
  logic [6:0]    pin_q, pin_d;
  gsci_pkg::out_t out_q, out_d;
  logic          ring_we;

  assign out_valid_o = (state_q == gsci_pkg::BK_OUT);
  assign out_o       = out_q;

  always_comb begin
    state_d     = state_q;
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    p1_d        = p1_q;
    p3_d        = p3_q;
    pin_d       = pin_q;
    out_d       = out_q;
    ring_we     = 1'b0;
    cmd_ready_o = 1'b0;
    case (state_q)
      gsci_pkg::BK_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          pin_d = (pin_q & ~cmd_i.pin_mask) | (cmd_i.pin_val & cmd_i.pin_mask);
          if (cmd_i.port1_we) begin
            p1_d = cmd_i.port_data;
          end
          if (cmd_i.port3_we) begin
            p3_d = cmd_i.port_data;
          end
          if (cmd_i.push_en) begin
            if (fill_q >= FW'(RING_DEPTH)) begin
              ovf_d = 1'b1;
            end else begin
              ring_we  = 1'b1;
              wr_ptr_d = (wr_ptr_q == PW'(RING_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
              fill_d   = fill_q + FW'(1);
            end
          end
          if (cmd_i.poll) begin
            cnt_d = fill_q;
            len_d = fill_q;
            if (fill_q == '0) begin
              out_d.data_byte   = 8'd0;
              out_d.data_valid  = 1'b0;
              out_d.last        = 1'b1;
              out_d.length      = 6'd0;
              out_d.port1_drive = p1_q;
              out_d.port3_drive = p3_q;
              out_d.pin_drive   = pin_q;
              out_d.overflow    = ovf_q;
              state_d           = gsci_pkg::BK_OUT;
            end else begin
              state_d = gsci_pkg::BK_LOAD;
            end
          end
        end
      end
      gsci_pkg::BK_LOAD: begin
        out_d.data_byte   = rdata_q;
        out_d.data_valid  = 1'b1;
        out_d.last        = (cnt_q == FW'(1));
        out_d.length      = 6'(len_q);
        out_d.port1_drive = p1_q;
        out_d.port3_drive = p3_q;
        out_d.pin_drive   = pin_q;
        out_d.overflow    = ovf_q;
        rd_ptr_d          = (rd_ptr_q == PW'(RING_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
        cnt_d             = cnt_q - FW'(1);
        state_d           = gsci_pkg::BK_OUT;
      end
      gsci_pkg::BK_OUT: begin
        if (out_ready_i) begin
          if (cnt_q == '0) begin
            fill_d  = '0;
            state_d = gsci_pkg::BK_IDLE;
          end else begin
            state_d = gsci_pkg::BK_LOAD;
          end
        end
      end
      default: begin
        state_d = gsci_pkg::BK_IDLE;
      end
    endcase
  end

  // ring storage, registered read at the read pointer
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring[wr_ptr_q] <= cmd_i.push_data;
    end
    rdata_q <= ring[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    len_q <= len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gsci_pkg::BK_IDLE;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      p1_q     <= gsci_pkg::PORT_RESET;
      p3_q     <= gsci_pkg::PORT_RESET;
      pin_q    <= gsci_pkg::PIN_RESET;
    end else begin
      state_q  <= state_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      p1_q     <= p1_d;
      p3_q     <= p3_d;
      pin_q    <= pin_d;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(RING_DEPTH))
    else $error("ring fill beyond depth");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(ovf_q))
    else $error("overflow flag cleared");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_q.last) |=> (fill_q == '0))
    else $error("ring not empty after final drained byte");

  a_load_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gsci_pkg::BK_LOAD) |-> (cnt_q != '0))
    else $error("ring read with no byte left");

endmodule

// ===== rtl/gpio_spi_command_interpreter.sv =====
// ----------------------------------------------------------------------------
// gpio_spi_command_interpreter
// decodes gpio/spi command bytes, queues read results and drains them on poll
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+--------------------------
//  input   | in_valid_i / in_ready_o  | in_i  (gsci_pkg::in_t)
//  output  | out_valid_o / out_ready_i| out_o (gsci_pkg::out_t)
//
//  a feed transfer is decoded in the cycle it arrives, then queued and
//  carried out by the back end, so feeds run at one per cycle while the
//  command queue has room; a poll runs ring read, then output register,
//  for each queued byte, an empty poll only the output register
//  reset clears phase, pointers, fill, overflow and sets all latches high
//  input stalls only when the two-entry command queue is full, i.e. while
//  the back end drains or waits on a stalled output
// ----------------------------------------------------------------------------
module gpio_spi_command_interpreter #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  gsci_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output gsci_pkg::out_t out_o
);

  // decoded commands, front to queue
  logic           fq_valid, fq_ready;
  gsci_pkg::cmd_t fq_cmd;
  // queue to back end
  logic           qb_valid, qb_ready;
  gsci_pkg::cmd_t qb_cmd;

  // opcode/operand tracking and decode
  gsci_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_o       (fq_cmd)
  );

  // decouples front and back so each can stall on its own
  gsci_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  (fq_cmd),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_data_o  (qb_cmd)
  );

  // latches, result ring and drain sequencer
  gsci_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (qb_valid),
    .cmd_ready_o (qb_ready),
    .cmd_i       (qb_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
